// ===== hw/rtl/friedman_key_length_estimator_assert.svh =====
// Assertion macros used by the checker of the key length estimator.
`ifndef FRIEDMAN_KEY_LENGTH_ESTIMATOR_ASSERT_SVH
`define FRIEDMAN_KEY_LENGTH_ESTIMATOR_ASSERT_SVH

// Check cons in the same cycle as ante.
`define FKLE_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check cons in the cycle after ante.
`define FKLE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/fkle_pkg.sv =====
// Types and constants of the key length estimator.
package fkle_pkg;

    localparam int NUM_LETTERS  = 26;
    localparam int LETTER_IDX_W = 5;
    localparam int KMAG_W       = 21;

    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;
    localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
    localparam logic [7:0] CASE_OFFSET  = 8'h20;

    localparam logic [15:0]       KP_RESET         = 16'd4371;
    localparam logic [KMAG_W-1:0] Q16_ONE          = 21'h10000;
    localparam logic [15:0]       LETTER_COUNT_MAX = 16'hFFFF;
    localparam logic [31:0]       EST_POS_MAX      = 32'h7FFF_FFFF;
    localparam logic [31:0]       EST_NEG_MAX      = 32'h8000_0000;
    localparam logic [32:0]       ROUND_HALF       = 33'h0_0000_8000;
    localparam logic [15:0]       RND_POS_MAX      = 16'h7FFF;
    localparam logic [16:0]       RND_POS_LIMIT    = 17'd32767;

    typedef struct packed {
        logic [7:0] char_code;
        logic       last_char;
    } fkle_req_t;

    typedef struct packed {
        logic signed [31:0] length_estimate;
        logic signed [15:0] rounded_length;
        logic [15:0]        letter_count;
        logic               uniform_text;
        logic               count_overflow;
    } fkle_result_t;

endpackage

// ===== hw/rtl/friedman_key_length_estimator.sv =====
// Friedman key length estimator: letter histogram and end-of-message estimate.
//
// Usage: drive one ciphertext byte per request on req with start high; a
// request is taken at a rising edge with start high and busy low. Letters
// A-Z and a-z are counted case-insensitively, every other byte is dropped.
// Bytes without last_char do not raise busy, so a message streams in at
// one byte per clock; the histogram lives in a 26-entry synchronous memory
// updated by read-modify-write, with forwarding of the previous write.
// A byte with last_char starts the estimate and raises busy. The block then
// drains the last update, sweeps the memory once through a shared multiplier
// (21x16 at the default width) to form the sum of squares, forms n^2, the
// denominator and the numerator, runs a restoring divider one quotient bit
// per cycle and rounds. done pulses with result when rounding finishes;
// busy falls in that same cycle, and a new request may be taken while
// done is high. The divider sets the message-end cost. The receiver
// takes every result: no back pressure.
// Write language_coincidence (Q0.16) with cfg_we/cfg_data while idle.
// Reset clears the counters, the valid bits and the flag, and loads the
// coincidence register with 0.0667; histogram entries read as zero until
// written in the current message, and all are released after each result.
module friedman_key_length_estimator #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    output logic                   busy,
    input  fkle_pkg::fkle_req_t    req,
    output logic                   done,
    output fkle_pkg::fkle_result_t result,
    input  logic                   cfg_we,
    input  logic [15:0]            cfg_data
);

    localparam int CW   = COUNT_WIDTH;
    localparam int KW   = fkle_pkg::KMAG_W;
    localparam int IW   = fkle_pkg::LETTER_IDX_W;
    localparam int MAW  = (CW > KW) ? CW : KW;
    localparam int PW   = MAW + CW;
    localparam int SW   = 2 * CW + 5;
    localparam int DENW = 2 * CW + 10;
    localparam int NUMW = 2 * CW + KW;
    localparam int DCW  = $clog2(NUMW + 1);
    localparam int LCW  = (CW > 16) ? CW : 16;

    localparam logic [CW-1:0]  COUNT_MAX  = {CW{1'b1}};
    localparam logic [IW-1:0]  SWEEP_LAST = IW'(fkle_pkg::NUM_LETTERS + 1);
    localparam logic [IW-1:0]  SWEEP_RDS  = IW'(fkle_pkg::NUM_LETTERS);
    localparam logic [DCW-1:0] DIV_LAST   = DCW'(NUMW - 1);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DRAIN,
        ST_SWEEP,
        ST_NSQ,
        ST_N2,
        ST_DEN,
        ST_KHI,
        ST_NUM,
        ST_DIV,
        ST_EST,
        ST_RND
    } state_t;

    state_t state_reg;

    // Histogram memory and its valid bits
    logic [CW-1:0]                    hist_mem [fkle_pkg::NUM_LETTERS];
    logic [fkle_pkg::NUM_LETTERS-1:0] ent_valid_reg;
    logic [CW-1:0]                    rdata_reg;
    logic                             rval_reg;
    logic [IW-1:0]                    raddr;

    // Update pipeline: stage 1 holds the letter whose count comes back now
    logic          s1_v_reg;
    logic [IW-1:0] s1_idx_reg;
    logic          wr_v_reg;
    logic [IW-1:0] wr_idx_reg;
    logic [CW-1:0] wr_data_reg;
    logic [CW-1:0] cur_count;
    logic [CW-1:0] count_next;
    logic          s1_sat;

    logic [15:0]   lang_reg;
    logic [CW-1:0] total_reg;
    logic          sat_reg;

    // Request decode
    logic          accept;
    logic          is_upper;
    logic [7:0]    ch_fold;
    logic          is_letter;
    logic [IW-1:0] letter_idx;
    logic          tot_sat;

    // End-of-message datapath
    logic [IW-1:0]   sweep_cnt_reg;
    logic            rd_v_reg;
    logic            mul_v_reg;
    logic [CW-1:0]   sq_count;
    logic [MAW-1:0]  mul_a;
    logic [CW-1:0]   mul_b;
    logic [PW-1:0]   product_reg;
    logic [SW-1:0]   s_reg;
    logic [2*CW-1:0] n2_reg;
    logic [KW-1:0]   k26;
    logic [KW-1:0]   kmag_reg;
    logic            kneg_reg;
    logic [DENW-1:0] s26;
    logic [DENW-1:0] n2_ext;
    logic            den_ge;
    logic [DENW-1:0] den_reg;
    logic            dneg_reg;
    logic            den_zero_reg;
    logic [NUMW-1:0] num_reg;

    // Divider
    logic [DENW-1:0] rem_reg;
    logic [DENW:0]   rem_shift;
    logic            q_bit;
    logic [DENW-1:0] rem_next;
    logic [32:0]     q_reg;
    logic            qovf_reg;
    logic [DCW-1:0]  div_cnt_reg;

    // Result forming
    logic            q_big;
    logic [31:0]     est_next;
    logic [31:0]     est_reg;
    logic            uniform_next;
    logic [31:0]     est_abs;
    logic [32:0]     rsum;
    logic [16:0]     rmag;
    logic [15:0]     rnd_next;
    logic [LCW-1:0]  tot_ext;
    logic [15:0]     letter_count_next;

    assign busy   = (state_reg != ST_IDLE);
    assign accept = start && !busy;

    // Fold upper case onto lower case, then map a..z to 0..25
    assign is_upper   = (req.char_code >= fkle_pkg::CHAR_UPPER_A) &&
                        (req.char_code <= fkle_pkg::CHAR_UPPER_Z);
    assign ch_fold    = is_upper ? (req.char_code + fkle_pkg::CASE_OFFSET) : req.char_code;
    assign is_letter  = (ch_fold >= fkle_pkg::CHAR_LOWER_A) &&
                        (ch_fold <= fkle_pkg::CHAR_LOWER_Z);
    assign letter_idx = IW'(ch_fold - fkle_pkg::CHAR_LOWER_A);
    assign tot_sat    = (total_reg == COUNT_MAX);

    assign raddr = (state_reg == ST_SWEEP) ? sweep_cnt_reg : letter_idx;

    // Forward the write of the previous cycle; an entry not yet valid reads as zero
    always_comb
    begin
        if (wr_v_reg && (wr_idx_reg == s1_idx_reg))
            cur_count = wr_data_reg;
        else if (rval_reg)
            cur_count = rdata_reg;
        else
            cur_count = '0;
        s1_sat     = (cur_count == COUNT_MAX);
        count_next = s1_sat ? cur_count : (cur_count + CW'(1));
    end

    assign sq_count = rval_reg ? rdata_reg : '0;

    // Operand select for the shared multiplier
    always_comb
    begin
        unique case (state_reg)
            ST_SWEEP:
            begin
                mul_a = MAW'(sq_count);
                mul_b = sq_count;
            end
            ST_NSQ:
            begin
                mul_a = MAW'(total_reg);
                mul_b = total_reg;
            end
            ST_DEN:
            begin
                mul_a = MAW'(kmag_reg);
                mul_b = n2_reg[CW-1:0];
            end
            ST_KHI:
            begin
                mul_a = MAW'(kmag_reg);
                mul_b = n2_reg[2*CW-1:CW];
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // k = 26*kp - 1 in Q16, kept as sign and magnitude
    assign k26 = KW'(lang_reg) * KW'(fkle_pkg::NUM_LETTERS);

    // Denominator 26*S - n^2, sign and magnitude
    assign s26    = (DENW'(s_reg) << 4) + (DENW'(s_reg) << 3) + (DENW'(s_reg) << 1);
    assign n2_ext = DENW'(n2_reg);
    assign den_ge = (s26 >= n2_ext);

    // One restoring step per cycle
    always_comb
    begin
        rem_shift = {rem_reg, num_reg[NUMW-1]};
        q_bit     = (rem_shift >= {1'b0, den_reg});
        rem_next  = q_bit ? DENW'(rem_shift - {1'b0, den_reg}) : rem_shift[DENW-1:0];
    end

    // Estimate with saturation and the special cases
    always_comb
    begin
        q_big        = qovf_reg || q_reg[32];
        uniform_next = 1'b0;
        if (total_reg == '0)
        begin
            est_next = kneg_reg ? 32'(kmag_reg) : (32'd0 - 32'(kmag_reg));
        end
        else if (den_zero_reg)
        begin
            est_next     = '0;
            uniform_next = 1'b1;
        end
        else if (kneg_reg != dneg_reg)
        begin
            if (q_big || (q_reg[31] && (q_reg[30:0] != '0)))
                est_next = fkle_pkg::EST_NEG_MAX;
            else
                est_next = 32'd0 - q_reg[31:0];
        end
        else
        begin
            if (q_big || q_reg[31])
                est_next = fkle_pkg::EST_POS_MAX;
            else
                est_next = q_reg[31:0];
        end
    end

    // Round half away from zero from the Q16.16 value
    always_comb
    begin
        est_abs = est_reg[31] ? (32'd0 - est_reg) : est_reg;
        rsum    = {1'b0, est_abs} + fkle_pkg::ROUND_HALF;
        rmag    = rsum[32:16];
        if (est_reg[31])
            rnd_next = 16'd0 - rmag[15:0];
        else if (rmag > fkle_pkg::RND_POS_LIMIT)
            rnd_next = fkle_pkg::RND_POS_MAX;
        else
            rnd_next = rmag[15:0];
    end

    assign tot_ext           = LCW'(total_reg);
    assign letter_count_next = (tot_ext > LCW'(fkle_pkg::LETTER_COUNT_MAX)) ?
                               fkle_pkg::LETTER_COUNT_MAX : tot_ext[15:0];

    // Histogram memory: write from stage 1, registered read
    always_ff @(posedge clk)
    begin
        if (s1_v_reg)
            hist_mem[s1_idx_reg] <= count_next;
        rdata_reg <= hist_mem[raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            done          <= 1'b0;
            result        <= '0;
            lang_reg      <= fkle_pkg::KP_RESET;
            ent_valid_reg <= '0;
            rval_reg      <= 1'b0;
            s1_v_reg      <= 1'b0;
            s1_idx_reg    <= '0;
            wr_v_reg      <= 1'b0;
            wr_idx_reg    <= '0;
            wr_data_reg   <= '0;
            total_reg     <= '0;
            sat_reg       <= 1'b0;
            sweep_cnt_reg <= '0;
            rd_v_reg      <= 1'b0;
            mul_v_reg     <= 1'b0;
            product_reg   <= '0;
            s_reg         <= '0;
            n2_reg        <= '0;
            kmag_reg      <= '0;
            kneg_reg      <= 1'b0;
            den_reg       <= '0;
            dneg_reg      <= 1'b0;
            den_zero_reg  <= 1'b0;
            num_reg       <= '0;
            rem_reg       <= '0;
            q_reg         <= '0;
            qovf_reg      <= 1'b0;
            div_cnt_reg   <= '0;
            est_reg       <= '0;
        end
        else
        begin
            done        <= 1'b0;
            rval_reg    <= ent_valid_reg[raddr];
            product_reg <= PW'(mul_a) * PW'(mul_b);

            if (cfg_we)
                lang_reg <= cfg_data;

            // Stage 1: write back the incremented count
            s1_v_reg    <= accept && is_letter;
            s1_idx_reg  <= letter_idx;
            wr_v_reg    <= s1_v_reg;
            wr_idx_reg  <= s1_idx_reg;
            wr_data_reg <= count_next;
            if (s1_v_reg)
            begin
                ent_valid_reg[s1_idx_reg] <= 1'b1;
                if (s1_sat)
                    sat_reg <= 1'b1;
            end

            if (accept && is_letter)
            begin
                if (tot_sat)
                    sat_reg <= 1'b1;
                else
                    total_reg <= total_reg + CW'(1);
            end

            // Sum of squares accumulates behind the sweep reads, through the read and product registers
            rd_v_reg  <= (state_reg == ST_SWEEP) && (sweep_cnt_reg < SWEEP_RDS);
            mul_v_reg <= rd_v_reg;
            if (mul_v_reg)
                s_reg <= s_reg + SW'(product_reg[2*CW-1:0]);

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept && req.last_char)
                        state_reg <= ST_DRAIN;
                end
                ST_DRAIN:
                begin
                    // Let the last byte's write land before the sweep reads
                    s_reg         <= '0;
                    sweep_cnt_reg <= '0;
                    kneg_reg      <= (k26 < fkle_pkg::Q16_ONE);
                    kmag_reg      <= (k26 < fkle_pkg::Q16_ONE) ?
                                     (fkle_pkg::Q16_ONE - k26) : (k26 - fkle_pkg::Q16_ONE);
                    state_reg     <= ST_SWEEP;
                end
                ST_SWEEP:
                begin
                    sweep_cnt_reg <= sweep_cnt_reg + IW'(1);
                    if (sweep_cnt_reg == SWEEP_LAST)
                        state_reg <= ST_NSQ;
                end
                ST_NSQ:
                begin
                    state_reg <= ST_N2;
                end
                ST_N2:
                begin
                    n2_reg    <= product_reg[2*CW-1:0];
                    state_reg <= ST_DEN;
                end
                ST_DEN:
                begin
                    den_reg      <= den_ge ? (s26 - n2_ext) : (n2_ext - s26);
                    dneg_reg     <= !den_ge;
                    den_zero_reg <= (s26 == n2_ext);
                    state_reg    <= ST_KHI;
                end
                ST_KHI:
                begin
                    num_reg   <= NUMW'(product_reg);
                    state_reg <= ST_NUM;
                end
                ST_NUM:
                begin
                    num_reg     <= num_reg + (NUMW'(product_reg) << CW);
                    rem_reg     <= '0;
                    q_reg       <= '0;
                    qovf_reg    <= 1'b0;
                    div_cnt_reg <= '0;
                    state_reg   <= ST_DIV;
                end
                ST_DIV:
                begin
                    rem_reg     <= rem_next;
                    num_reg     <= num_reg << 1;
                    q_reg       <= {q_reg[31:0], q_bit};
                    qovf_reg    <= qovf_reg || q_reg[32];
                    div_cnt_reg <= div_cnt_reg + DCW'(1);
                    if (div_cnt_reg == DIV_LAST)
                        state_reg <= ST_EST;
                end
                ST_EST:
                begin
                    est_reg             <= est_next;
                    result.uniform_text <= uniform_next;
                    state_reg           <= ST_RND;
                end
                ST_RND:
                begin
                    result.length_estimate <= est_reg;
                    result.rounded_length  <= rnd_next;
                    result.letter_count    <= letter_count_next;
                    result.count_overflow  <= sat_reg;
                    done                   <= 1'b1;
                    // Release the histogram for the next message
                    ent_valid_reg          <= '0;
                    total_reg              <= '0;
                    sat_reg                <= 1'b0;
                    state_reg              <= ST_IDLE;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== hw/rtl/fkle_checker.sv =====
// Port-level checker of the key length estimator and its bind.
`include "friedman_key_length_estimator_assert.svh"

module fkle_checker (
    input logic                   clk,
    input logic                   rst_n,
    input logic                   start,
    input logic                   busy,
    input fkle_pkg::fkle_req_t    req,
    input logic                   done,
    input fkle_pkg::fkle_result_t result
);

    `FKLE_ASSERT_NEXT(a_byte_one_cycle, start && !busy && !req.last_char, !busy, "byte held the block busy")
    `FKLE_ASSERT_NEXT(a_last_goes_busy, start && !busy && req.last_char, busy && !done, "last byte did not start the estimate")
    `FKLE_ASSERT_NOW(a_done_idle, done, !busy, "result shown while busy")
    `FKLE_ASSERT_NEXT(a_done_single, done, !done, "more than one result for a message")
    `FKLE_ASSERT_NOW(a_uniform_zero, done && result.uniform_text, (result.length_estimate == 0) && (result.rounded_length == 0), "uniform text gave a nonzero estimate")

endmodule

bind friedman_key_length_estimator fkle_checker u_fkle_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .req    (req),
    .done   (done),
    .result (result)
);

// ===== tb/friedman_key_length_estimator_test.sv =====
// Self-checking testbench of the Friedman key length estimator.
`timescale 1ns / 1ps

module friedman_key_length_estimator_test;

    // Settle time after draining, with margin over what one estimate takes.
    localparam int SETTLE_CYCLES = 120;
    localparam int STALL_LIMIT   = 2000;
    localparam int REPORT_LIMIT  = 10;

    logic                   clk      = 1'b0;
    logic                   rst_n    = 1'b0;
    logic                   start    = 1'b0;
    logic                   busy;
    fkle_pkg::fkle_req_t    req      = '0;
    logic                   done;
    fkle_pkg::fkle_result_t result;
    logic                   cfg_we   = 1'b0;
    logic [15:0]            cfg_data = '0;

    // Requests waiting to go out, and the estimates still owed by the block.
    fkle_pkg::fkle_req_t    byte_queue[$];
    fkle_pkg::fkle_result_t estimate_queue[$];

    // Shadow of the block: letter histogram, letter total, saturation flag and
    // the coincidence register.
    logic [15:0]  letter_hist[fkle_pkg::NUM_LETTERS];
    logic [15:0]  letter_sum;
    logic         hist_saturated;
    logic [15:0]  kp_q16;

    int           gap_pct = 37;
    logic         req_taken = 1'b0;
    int           quiet_cycles = 0;
    int           mismatch_count = 0;

    friedman_key_length_estimator i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .req      (req),
        .done     (done),
        .result   (result),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data)
    );

    always #6 clk = ~clk;

    // Fold one byte into the shadow histogram; fold case, drop non-letters.
    function automatic void tally_char(input logic [7:0] code);
        logic [7:0] ch;
        int         idx;
        ch = code;
        if (ch >= fkle_pkg::CHAR_UPPER_A && ch <= fkle_pkg::CHAR_UPPER_Z)
            ch = ch + fkle_pkg::CASE_OFFSET;
        if (ch >= fkle_pkg::CHAR_LOWER_A && ch <= fkle_pkg::CHAR_LOWER_Z)
        begin
            idx = int'(ch - fkle_pkg::CHAR_LOWER_A);
            if (letter_hist[idx] == fkle_pkg::LETTER_COUNT_MAX)
                hist_saturated = 1'b1;
            else
                letter_hist[idx] = letter_hist[idx] + 16'd1;
            if (letter_sum == fkle_pkg::LETTER_COUNT_MAX)
                hist_saturated = 1'b1;
            else
                letter_sum = letter_sum + 16'd1;
        end
    endfunction

    // Close the message: form the estimate exactly in wide integers, then clear
    // the histogram for the next message.
    function automatic fkle_pkg::fkle_result_t close_message();
        fkle_pkg::fkle_result_t r;
        longint          k;
        longint          est;
        longint          rnd;
        longint unsigned r_mag;
        logic [63:0]     k_mag;
        logic [127:0]    sq_sum;
        logic [127:0]    sq_sum26;
        logic [127:0]    n_sq;
        logic [127:0]    den;
        logic [127:0]    quo;
        bit              k_neg;
        bit              d_neg;
        bit              uniform;
        uniform = 1'b0;
        k       = 26 * longint'(kp_q16) - 65536;
        k_neg   = k < 0;
        k_mag   = k_neg ? -k : k;
        if (letter_sum == 0)
        begin
            est = -k;
        end
        else
        begin
            sq_sum = '0;
            for (int i = 0; i < fkle_pkg::NUM_LETTERS; i++)
                sq_sum += 128'(letter_hist[i]) * 128'(letter_hist[i]);
            sq_sum26 = sq_sum * 128'(26);
            n_sq     = 128'(letter_sum) * 128'(letter_sum);
            d_neg    = sq_sum26 < n_sq;
            den      = d_neg ? n_sq - sq_sum26 : sq_sum26 - n_sq;
            if (den == 0)
            begin
                uniform = 1'b1;
                est     = 0;
            end
            else
            begin
                quo = (128'(k_mag) * n_sq) / den;
                if (k_neg != d_neg)
                    est = (quo > 128'(fkle_pkg::EST_NEG_MAX)) ? -64'sd2147483648
                                                              : -longint'(quo[63:0]);
                else
                    est = (quo > 128'(fkle_pkg::EST_POS_MAX)) ? 64'sd2147483647
                                                              : longint'(quo[63:0]);
            end
        end
        // Round half away from zero on the magnitude, then saturate to 16 bits.
        r_mag = (est < 0 ? -est : est) + 32768;
        r_mag = r_mag >> 16;
        if (est < 0)
            rnd = (r_mag > 32768) ? -64'sd32768 : -longint'(r_mag);
        else
            rnd = (r_mag > 32767) ? 64'sd32767 : longint'(r_mag);
        r.length_estimate = est[31:0];
        r.rounded_length  = rnd[15:0];
        r.letter_count    = letter_sum;
        r.uniform_text    = uniform;
        r.count_overflow  = hist_saturated;
        foreach (letter_hist[i])
            letter_hist[i] = '0;
        letter_sum     = '0;
        hist_saturated = 1'b0;
        return r;
    endfunction

    task automatic note_failure(input string what, input fkle_pkg::fkle_result_t want,
                                input fkle_pkg::fkle_result_t got);
        if (mismatch_count < REPORT_LIMIT)
            $display("%0t %s: want est=%h rnd=%h n=%0d uni=%b ovf=%b", $time, what,
                     want.length_estimate, want.rounded_length, want.letter_count,
                     want.uniform_text, want.count_overflow,
                     "\n    got  est=%h rnd=%h n=%0d uni=%b ovf=%b",
                     got.length_estimate, got.rounded_length, got.letter_count,
                     got.uniform_text, got.count_overflow);
        mismatch_count++;
    endtask

    // Driver: change inputs on the falling edge. Hold a request until the
    // block takes it, then either send the next one or leave start low.
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
        end
        else if (!start || req_taken)
        begin
            if (byte_queue.size() != 0 && $urandom_range(0, 99) >= gap_pct)
            begin
                req   <= byte_queue.pop_front();
                start <= 1'b1;
            end
            else
            begin
                start <= 1'b0;
            end
        end
    end

    // Monitor: sample on the rising edge. Check a finished estimate before
    // folding in the request taken at the same edge, since that estimate
    // always belongs to an earlier message.
    always @(posedge clk)
    begin : monitor
        fkle_pkg::fkle_result_t want;
        if (!rst_n)
        begin
            req_taken    <= 1'b0;
            quiet_cycles <= 0;
        end
        else
        begin
            if (done)
            begin
                if (estimate_queue.size() == 0)
                begin
                    note_failure("estimate with no message behind it", '0, result);
                end
                else
                begin
                    want = estimate_queue.pop_front();
                    if (result.length_estimate !== want.length_estimate ||
                        result.rounded_length  !== want.rounded_length  ||
                        result.letter_count    !== want.letter_count    ||
                        result.uniform_text    !== want.uniform_text    ||
                        result.count_overflow  !== want.count_overflow)
                        note_failure("estimate mismatch", want, result);
                end
            end
            if (start && !busy)
            begin
                tally_char(req.char_code);
                if (req.last_char)
                    estimate_queue = {estimate_queue, close_message()};
            end
            req_taken <= start && !busy;
            // Watchdog: count cycles with neither a request taken nor a result.
            if ((start && !busy) || done)
            begin
                quiet_cycles <= 0;
            end
            else if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("friedman_key_length_estimator regression: fail");
                $finish;
            end
            else
            begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    task automatic queue_byte(input logic [7:0] ch, input bit last);
        fkle_pkg::fkle_req_t r;
        r.char_code = ch;
        r.last_char = last;
        byte_queue  = {byte_queue, r};
    endtask

    // Hold until every request is taken and every estimate has come back,
    // then let the block finish any trailing update.
    task automatic drain_and_settle();
        while (byte_queue.size() != 0 || start || estimate_queue.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write the coincidence register while the block is idle.
    task automatic write_kp(input logic [15:0] value);
        drain_and_settle();
        @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(negedge clk);
        cfg_we   <= 1'b0;
        kp_q16    = value;
    endtask

    // Every letter reps times in random case, then extra_count more of one
    // letter; last on the final byte. No extras gives a zero denominator, a
    // single extra on a long run gives a huge estimate.
    task automatic push_alphabet_run(input int reps, input int extra_letter,
                                     input int extra_count);
        int         total;
        int         pos;
        logic [7:0] ch;
        total = reps * fkle_pkg::NUM_LETTERS + extra_count;
        pos   = 0;
        for (int r = 0; r < reps; r++)
        begin
            for (int i = 0; i < fkle_pkg::NUM_LETTERS; i++)
            begin
                ch = 8'(fkle_pkg::CHAR_LOWER_A + i);
                if ($urandom_range(0, 1))
                    ch = ch - fkle_pkg::CASE_OFFSET;
                pos++;
                queue_byte(ch, pos == total);
            end
        end
        for (int e = 0; e < extra_count; e++)
        begin
            ch = 8'(fkle_pkg::CHAR_LOWER_A + extra_letter);
            if ($urandom_range(0, 1))
                ch = ch - fkle_pkg::CASE_OFFSET;
            pos++;
            queue_byte(ch, pos == total);
        end
    endtask

    // Random message: letters drawn from the first span letters, either case,
    // mixed with arbitrary bytes; last on the final byte.
    task automatic push_random_message(input int len, input int span);
        int         sel;
        logic [7:0] ch;
        for (int i = 0; i < len; i++)
        begin
            sel = $urandom_range(0, 99);
            ch  = 8'(fkle_pkg::CHAR_LOWER_A + $urandom_range(0, span - 1));
            if (sel >= 75)
                ch = 8'($urandom_range(0, 255));
            else if (sel >= 45)
                ch = ch - fkle_pkg::CASE_OFFSET;
            queue_byte(ch, i == len - 1);
        end
    endtask

    task automatic random_phase(input logic [15:0] kp, input int target, input int pct);
        int queued;
        int sel;
        int len;
        int extra;
        write_kp(kp);
        gap_pct = pct;
        queued  = 0;
        while (queued < target)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 4)
            begin
                len   = $urandom_range(1, 3);
                extra = $urandom_range(0, 2);
                push_alphabet_run(len, $urandom_range(0, fkle_pkg::NUM_LETTERS - 1), extra);
                queued += len * fkle_pkg::NUM_LETTERS + extra;
            end
            else
            begin
                len = (sel < 10) ? $urandom_range(40, 120) : $urandom_range(1, 20);
                push_random_message(len, $urandom_range(1, fkle_pkg::NUM_LETTERS));
                queued += len;
            end
        end
    endtask

    initial
    begin
        foreach (letter_hist[i])
            letter_hist[i] = '0;
        letter_sum     = '0;
        hist_saturated = 1'b0;
        kp_q16         = fkle_pkg::KP_RESET;

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed, reset coincidence: single letter, empty messages of one
        // non-letter, the bytes around the letter ranges, and a flat alphabet.
        queue_byte("A", 1'b1);
        queue_byte(8'h00, 1'b1);
        queue_byte(8'hFF, 1'b1);
        queue_byte(8'h40, 1'b0);
        queue_byte(8'h5A, 1'b0);
        queue_byte(8'h5B, 1'b0);
        queue_byte(8'h60, 1'b0);
        queue_byte(8'h7A, 1'b0);
        queue_byte(8'h7B, 1'b0);
        queue_byte(8'h80, 1'b0);
        queue_byte("a", 1'b1);
        push_alphabet_run(1, 0, 0);

        // Zero coincidence: negative constant, so no letters gives +1.0 and a
        // near-flat text gives a large negative estimate.
        write_kp(16'h0000);
        queue_byte(8'h20, 1'b1);
        push_alphabet_run(4, 7, 1);
        push_alphabet_run(1, 0, 0);
        queue_byte("A", 1'b1);

        // Full-scale coincidence: large positive constant, positive rail.
        write_kp(16'hFFFF);
        queue_byte(8'h7F, 1'b1);
        push_alphabet_run(7, 3, 1);
        for (int m = 0; m < 5; m++)
            push_random_message($urandom_range(1, 20),
                                $urandom_range(1, fkle_pkg::NUM_LETTERS));

        // Constants just either side of zero.
        write_kp(16'd2521);
        for (int m = 0; m < 4; m++)
            push_random_message($urandom_range(1, 20),
                                $urandom_range(1, fkle_pkg::NUM_LETTERS));
        write_kp(16'd2520);
        for (int m = 0; m < 4; m++)
            push_random_message($urandom_range(1, 20),
                                $urandom_range(1, fkle_pkg::NUM_LETTERS));

        // Random messages across several coincidence settings; one phase
        // runs with no idling at all.
        for (int p = 0; p < 6; p++)
            random_phase(16'($urandom_range(0, 65535)), 60, (p == 2) ? 0 : 37);

        drain_and_settle();
        mismatch_count += estimate_queue.size();
        if (mismatch_count == 0)
            $display("friedman_key_length_estimator regression: pass");
        else
            $display("friedman_key_length_estimator regression: fail");
        $finish;
    end

endmodule
